// ===== rtl/modbus_rtu_slave_frame_engine_defines.svh =====
// Assertion macros shared by the frame engine checker.
`ifndef MODBUS_RTU_SLAVE_FRAME_ENGINE_DEFINES_SVH
`define MODBUS_RTU_SLAVE_FRAME_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define MBRTU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define MBRTU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mbrtu_pkg.sv =====
// Types, constants and codes of the Modbus RTU slave frame engine.
`default_nettype none
package mbrtu_pkg;

  // Default sizes of the stores.
  localparam int unsigned FRAME_BYTES_DEF = 64;
  localparam int unsigned NUM_REGS_DEF    = 16;
  localparam int unsigned NUM_COILS_DEF   = 64;

  // CRC-16 of the RTU framing, reflected form.
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // Addresses, function codes and exception codes.
  localparam logic [7:0] BCAST_ADDR     = 8'h00;
  localparam logic [7:0] FN_READ_COILS  = 8'h01;
  localparam logic [7:0] FN_READ_REGS   = 8'h03;
  localparam logic [7:0] FN_WRITE_COIL  = 8'h05;
  localparam logic [7:0] FN_WRITE_REG   = 8'h06;
  localparam logic [7:0] EXC_FLAG       = 8'h80;
  localparam logic [7:0] EXC_ILL_FUNC   = 8'h01;
  localparam logic [7:0] EXC_ILL_ADDR   = 8'h02;
  localparam logic [7:0] EXC_ILL_VALUE  = 8'h03;
  localparam logic [7:0] EXC_DEV_FAIL   = 8'h04;
  localparam logic [15:0] COIL_ON       = 16'hFF00;
  localparam logic [15:0] COIL_OFF      = 16'h0000;
  localparam logic [3:0] HDR_BYTES      = 4'd8;

  // Input item: a received byte or a frame end.
  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } req_t;

  // Output item: one response byte.
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_last;
  } resp_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_CRC, ST_LOAD, ST_DECIDE, ST_WRITE,
    ST_PREP, ST_RFETCH, ST_CREAD, ST_CSHIFT, ST_RCRC, ST_SEND
  } state_e;

  typedef enum logic [1:0] {
    KIND_ECHO, KIND_REGS, KIND_COILS, KIND_EXC
  } kind_e;

  // One bit step of the reflected CRC.
  function automatic logic [15:0] crc_step(input logic [15:0] crc);
    crc_step = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/mbrtu_ram.sv =====
// Generic single-write, single-read RAM with a registered read.
`default_nettype none
module mbrtu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/modbus_rtu_slave_frame_engine.sv =====
// Top level of the Modbus RTU slave frame engine.
// Received bytes and frame-end events enter on the input channel; response bytes leave on
// the output channel with tx_last on the final one. A received byte is accepted and stored in
// the frame RAM while there is room, and then folded into the shared serial CRC register in
// eight bit steps. At frame end the engine reads the first eight frame bytes from the frame
// RAM, decides, performs a write for functions 05 and 06, and then builds the response one
// byte at a time: it selects the byte (with a register fetch at the start of each register,
// or a read and a shift per coil for a coil byte), takes eight CRC bit steps for bytes
// covered by the CRC, and holds the byte in the output register until the transaction
// completes. After reset a clearing pass zeroes the register and coil RAMs; no input is
// taken during it, while the address register can be written as ever.
`default_nettype none
module modbus_rtu_slave_frame_engine
  import mbrtu_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF,
  parameter int unsigned NUM_REGS    = NUM_REGS_DEF,
  parameter int unsigned NUM_COILS   = NUM_COILS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire req_t       in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output resp_t           out_data_o
);

  localparam int unsigned FA_W  = $clog2(FRAME_BYTES);
  localparam int unsigned LEN_W = $clog2(FRAME_BYTES + 1);
  localparam int unsigned RA_W  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int unsigned CA_W  = (NUM_COILS > 1) ? $clog2(NUM_COILS) : 1;
  localparam int unsigned REM_W = $clog2(NUM_COILS + 1);
  localparam int unsigned CLR_N = (NUM_REGS > NUM_COILS) ? NUM_REGS : NUM_COILS;
  localparam int unsigned CLR_W = $clog2(CLR_N + 1);
  localparam int unsigned DATA_MAX = (2 * NUM_REGS > (NUM_COILS + 7) / 8) ?
                                     2 * NUM_REGS : (NUM_COILS + 7) / 8;
  localparam int unsigned POS_W = $clog2(DATA_MAX + 6);

  state_e            state_q, state_d;
  kind_e             kind_q, kind_d;
  logic [15:0]       crc_q, crc_d;
  logic [2:0]        bit_q, bit_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic              acc_en_q, acc_en_d;
  logic [7:0]        dev_addr_q, dev_addr_d;
  logic [CLR_W-1:0]  clr_q, clr_d;
  logic [3:0]        ld_q, ld_d;
  logic [7:0]        hdr_q [8];
  logic [7:0]        hdr_d [8];
  logic [7:0]        exc_q, exc_d;
  logic [POS_W-1:0]  body_q, body_d, total_q, total_d, pos_q, pos_d;
  logic [RA_W-1:0]   reg_idx_q, reg_idx_d;
  logic [15:0]       reg_word_q, reg_word_d;
  logic [CA_W-1:0]   cidx_q, cidx_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [3:0]        cnt_q, cnt_d;
  logic [7:0]        cbyte_q, cbyte_d;
  logic [7:0]        tx_q, tx_d;

  // RAM ports.
  logic              fr_we;
  logic [FA_W-1:0]   fr_waddr, fr_raddr;
  logic [7:0]        fr_rdata;
  logic              rg_we;
  logic [RA_W-1:0]   rg_waddr;
  logic [15:0]       rg_wdata, rg_rdata;
  logic              cl_we;
  logic [CA_W-1:0]   cl_waddr;
  logic              cl_wdata, cl_rdata;

  mbrtu_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_frame_ram (
    .clk_i, .we_i(fr_we), .waddr_i(fr_waddr), .wdata_i(in_data_i.rx_byte),
    .raddr_i(fr_raddr), .rdata_o(fr_rdata)
  );

  mbrtu_ram #(.WIDTH(16), .DEPTH(NUM_REGS)) u_reg_ram (
    .clk_i, .we_i(rg_we), .waddr_i(rg_waddr), .wdata_i(rg_wdata),
    .raddr_i(reg_idx_q), .rdata_o(rg_rdata)
  );

  mbrtu_ram #(.WIDTH(1), .DEPTH(NUM_COILS)) u_coil_ram (
    .clk_i, .we_i(cl_we), .waddr_i(cl_waddr), .wdata_i(cl_wdata),
    .raddr_i(cidx_q), .rdata_o(cl_rdata)
  );

  // Decoded request fields and handshakes.
  logic [7:0]  fn;
  logic [15:0] first, arg;
  logic [16:0] span;
  logic        in_fire, cfg_fire, out_fire, is_byte, foreign, good, len8, bcast;
  logic        last_byte, clr_done;

  assign fn        = hdr_q[1];
  assign first     = {hdr_q[2], hdr_q[3]};
  assign arg       = {hdr_q[4], hdr_q[5]};
  assign span      = {1'b0, first} + {1'b0, arg};
  assign in_fire   = in_valid_i && in_ready_o;
  assign cfg_fire  = cfg_valid_i && cfg_ready_o;
  assign out_fire  = out_valid_o && out_ready_i;
  assign is_byte   = !in_data_i.req_type;
  assign foreign   = (len_q == '0) && (in_data_i.rx_byte != BCAST_ADDR) &&
                     (in_data_i.rx_byte != dev_addr_q);
  assign good      = (crc_q == 16'h0000) && (len_q >= LEN_W'(2));
  assign len8      = (len_q == LEN_W'(HDR_BYTES));
  assign bcast     = (hdr_q[0] == BCAST_ADDR);
  assign last_byte = (pos_q == total_q - POS_W'(1));
  assign clr_done  = (clr_q == CLR_W'(CLR_N - 1));

  // Response byte selection for the current position.
  logic [7:0] prep_byte;
  logic       prep_fold, prep_reg, prep_coil;
  always_comb begin
    prep_byte = 8'h00;
    prep_fold = 1'b1;
    prep_reg  = 1'b0;
    prep_coil = 1'b0;
    if (kind_q == KIND_ECHO) begin
      prep_byte = hdr_q[pos_q[2:0]];
      prep_fold = 1'b0;
    end else if (pos_q == POS_W'(0)) begin
      prep_byte = hdr_q[0];
    end else if (pos_q == POS_W'(1)) begin
      prep_byte = (kind_q == KIND_EXC) ? (hdr_q[1] | EXC_FLAG) : hdr_q[1];
    end else if (pos_q == POS_W'(2)) begin
      if (kind_q == KIND_EXC) begin
        prep_byte = exc_q;
      end else if (kind_q == KIND_REGS) begin
        prep_byte = 8'(arg << 1);
      end else begin
        prep_byte = 8'(body_q - POS_W'(3));
      end
    end else if (pos_q == body_q) begin
      prep_byte = crc_q[7:0];
      prep_fold = 1'b0;
    end else if (pos_q == body_q + POS_W'(1)) begin
      prep_byte = crc_q[15:8];
      prep_fold = 1'b0;
    end else if (kind_q == KIND_REGS) begin
      // An odd position starts a new register, high byte first.
      prep_reg  = pos_q[0];
      prep_byte = reg_word_q[7:0];
    end else begin
      prep_coil = 1'b1;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (clr_done) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_fire) begin
          if (is_byte) begin
            if (acc_en_q) state_d = ST_CRC;
          end else if (acc_en_q) begin
            state_d = ST_LOAD;
          end
        end
      end
      ST_CRC:    if (bit_q == 3'd7) state_d = ST_IDLE;
      ST_LOAD:   if (ld_q == HDR_BYTES) state_d = ST_DECIDE;
      ST_DECIDE: begin
        if (!good) begin
          state_d = ST_IDLE;
        end else if (len8 && (fn == FN_WRITE_REG || fn == FN_WRITE_COIL)) begin
          state_d = ST_WRITE;
        end else begin
          state_d = bcast ? ST_IDLE : ST_PREP;
        end
      end
      ST_WRITE:  state_d = bcast ? ST_IDLE : ST_PREP;
      ST_PREP: begin
        if (prep_reg) begin
          state_d = ST_RFETCH;
        end else if (prep_coil) begin
          state_d = ST_CREAD;
        end else begin
          state_d = prep_fold ? ST_RCRC : ST_SEND;
        end
      end
      ST_RFETCH: state_d = ST_RCRC;
      ST_CREAD:  state_d = ST_CSHIFT;
      ST_CSHIFT: state_d = (cnt_q == 4'd1) ? ST_RCRC : ST_CREAD;
      ST_RCRC:   if (bit_q == 3'd7) state_d = ST_SEND;
      ST_SEND: begin
        if (out_fire) state_d = last_byte ? ST_IDLE : ST_PREP;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Datapath and RAM control.
  always_comb begin
    logic fin;
    logic in_rng_c;
    fin        = 1'b0;
    in_rng_c   = (first < 16'(NUM_COILS));
    crc_d      = crc_q;
    bit_d      = bit_q;
    len_d      = len_q;
    acc_en_d   = acc_en_q;
    dev_addr_d = cfg_fire ? cfg_data_i : dev_addr_q;
    clr_d      = clr_q;
    ld_d       = ld_q;
    hdr_d      = hdr_q;
    kind_d     = kind_q;
    exc_d      = exc_q;
    body_d     = body_q;
    total_d    = total_q;
    pos_d      = pos_q;
    reg_idx_d  = reg_idx_q;
    reg_word_d = reg_word_q;
    cidx_d     = cidx_q;
    rem_d      = rem_q;
    cnt_d      = cnt_q;
    cbyte_d    = cbyte_q;
    tx_d       = tx_q;
    fr_we      = 1'b0;
    fr_waddr   = len_q[FA_W-1:0];
    fr_raddr   = FA_W'(ld_q[2:0]);
    rg_we      = 1'b0;
    rg_waddr   = first[RA_W-1:0];
    rg_wdata   = arg;
    cl_we      = 1'b0;
    cl_waddr   = first[CA_W-1:0];
    cl_wdata   = (arg == COIL_ON);
    unique case (state_q)
      ST_CLEAR: begin
        rg_we    = (clr_q < CLR_W'(NUM_REGS));
        rg_waddr = clr_q[RA_W-1:0];
        rg_wdata = 16'h0000;
        cl_we    = (clr_q < CLR_W'(NUM_COILS));
        cl_waddr = clr_q[CA_W-1:0];
        cl_wdata = 1'b0;
        clr_d    = clr_q + CLR_W'(1);
      end
      ST_IDLE: begin
        ld_d = 4'd0;
        if (in_fire) begin
          if (!is_byte) begin
            if (!acc_en_q) fin = 1'b1;
          end else if (acc_en_q) begin
            // Fold the byte into the CRC and store it while there is room.
            crc_d = crc_q ^ {8'h00, in_data_i.rx_byte};
            bit_d = 3'd0;
            if (len_q < LEN_W'(FRAME_BYTES)) begin
              if (foreign) begin
                acc_en_d = 1'b0;
              end else begin
                fr_we = 1'b1;
                len_d = len_q + LEN_W'(1);
              end
            end
          end
        end
      end
      ST_CRC: begin
        crc_d = crc_step(crc_q);
        bit_d = bit_q + 3'd1;
      end
      ST_LOAD: begin
        if (ld_q != 4'd0) hdr_d[ld_q[2:0] - 3'd1] = fr_rdata;
        ld_d = ld_q + 4'd1;
      end
      ST_DECIDE: begin
        crc_d     = CRC_INIT;
        pos_d     = '0;
        reg_idx_d = first[RA_W-1:0];
        cidx_d    = first[CA_W-1:0];
        rem_d     = arg[REM_W-1:0];
        exc_d     = EXC_ILL_FUNC;
        kind_d    = KIND_EXC;
        body_d    = POS_W'(3);
        if (len8 && (fn == FN_WRITE_REG || fn == FN_WRITE_COIL)) begin
          kind_d = KIND_ECHO;
        end else if (len8 && fn == FN_READ_REGS) begin
          if (arg == 16'h0000 || arg > 16'(NUM_REGS)) begin
            exc_d = EXC_ILL_VALUE;
          end else if (span > 17'(NUM_REGS)) begin
            exc_d = EXC_ILL_ADDR;
          end else begin
            kind_d = KIND_REGS;
            body_d = POS_W'(3) + (POS_W'(arg) << 1);
          end
        end else if (len8 && fn == FN_READ_COILS) begin
          if (arg == 16'h0000 || arg > 16'(NUM_COILS)) begin
            exc_d = EXC_ILL_VALUE;
          end else if (span > 17'(NUM_COILS)) begin
            exc_d = EXC_ILL_ADDR;
          end else begin
            kind_d = KIND_COILS;
            body_d = POS_W'(3) + POS_W'((span - {1'b0, first} + 17'd7) >> 3);
          end
        end
        total_d = (kind_d == KIND_ECHO) ? POS_W'(HDR_BYTES) : body_d + POS_W'(2);
        if (!good) begin
          fin = 1'b1;
        end else if (kind_d != KIND_ECHO && bcast) begin
          fin = 1'b1;
        end
      end
      ST_WRITE: begin
        rg_we = (fn == FN_WRITE_REG) && (first < 16'(NUM_REGS));
        cl_we = (fn == FN_WRITE_COIL) && in_rng_c && (arg == COIL_ON || arg == COIL_OFF);
        if (bcast) fin = 1'b1;
      end
      ST_PREP: begin
        if (prep_coil) begin
          cbyte_d = 8'h00;
          cnt_d   = (rem_q >= REM_W'(8)) ? 4'd8 : 4'(rem_q);
        end else if (!prep_reg) begin
          tx_d = prep_byte;
          if (prep_fold) begin
            crc_d = crc_q ^ {8'h00, prep_byte};
            bit_d = 3'd0;
          end
        end
      end
      ST_RFETCH: begin
        reg_word_d = rg_rdata;
        reg_idx_d  = reg_idx_q + RA_W'(1);
        tx_d       = rg_rdata[15:8];
        crc_d      = crc_q ^ {8'h00, rg_rdata[15:8]};
        bit_d      = 3'd0;
      end
      ST_CREAD: begin
        cidx_d = cidx_q + CA_W'(1);
      end
      ST_CSHIFT: begin
        // Each coil shifts the byte left and enters at bit 0.
        cbyte_d = {cbyte_q[6:0], cl_rdata};
        cnt_d   = cnt_q - 4'd1;
        rem_d   = rem_q - REM_W'(1);
        if (cnt_q == 4'd1) begin
          tx_d  = {cbyte_q[6:0], cl_rdata};
          crc_d = crc_q ^ {8'h00, cbyte_q[6:0], cl_rdata};
          bit_d = 3'd0;
        end
      end
      ST_RCRC: begin
        crc_d = crc_step(crc_q);
        bit_d = bit_q + 3'd1;
      end
      ST_SEND: begin
        if (out_fire) begin
          pos_d = pos_q + POS_W'(1);
          if (last_byte) fin = 1'b1;
        end
      end
      default: begin
        fin = 1'b1;
      end
    endcase
    // Return the frame state to its reset values at the end of every frame.
    if (fin) begin
      crc_d    = CRC_INIT;
      len_d    = '0;
      acc_en_d = 1'b1;
    end
  end

  // Handshake outputs.
  assign cfg_ready_o        = 1'b1;
  assign in_ready_o         = (state_q == ST_IDLE);
  assign out_valid_o        = (state_q == ST_SEND);
  assign out_data_o.tx_byte = tx_q;
  assign out_data_o.tx_last = last_byte;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      crc_q      <= CRC_INIT;
      bit_q      <= 3'd0;
      len_q      <= '0;
      acc_en_q   <= 1'b1;
      dev_addr_q <= 8'h00;
      clr_q      <= '0;
      ld_q       <= 4'd0;
      pos_q      <= '0;
      total_q    <= '0;
      cnt_q      <= 4'd0;
    end else begin
      state_q    <= state_d;
      crc_q      <= crc_d;
      bit_q      <= bit_d;
      len_q      <= len_d;
      acc_en_q   <= acc_en_d;
      dev_addr_q <= dev_addr_d;
      clr_q      <= clr_d;
      ld_q       <= ld_d;
      pos_q      <= pos_d;
      total_q    <= total_d;
      cnt_q      <= cnt_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    hdr_q      <= hdr_d;
    kind_q     <= kind_d;
    exc_q      <= exc_d;
    body_q     <= body_d;
    reg_idx_q  <= reg_idx_d;
    reg_word_q <= reg_word_d;
    cidx_q     <= cidx_d;
    rem_q      <= rem_d;
    cbyte_q    <= cbyte_d;
    tx_q       <= tx_d;
  end

endmodule
`default_nettype wire

// ===== rtl/mbrtu_checker.sv =====
// Port-level checker of the frame engine, bound to the top level.
`default_nettype none
`include "modbus_rtu_slave_frame_engine_defines.svh"
module mbrtu_checker
  import mbrtu_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       cfg_valid_i,
  input wire logic       cfg_ready_o,
  input wire logic [7:0] cfg_data_i,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire req_t       in_data_i,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire resp_t      out_data_o
);

  // A pending response byte stays offered until its transaction completes.
  `MBRTU_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "response dropped")

  // Input is never taken while a response byte is on offer.
  `MBRTU_ASSERT_NOW(a_no_overlap, out_valid_o, !in_ready_o, "input open during response")

  // The last response byte hands control back to the input side.
  `MBRTU_ASSERT_NEXT(a_last_idle, out_valid_o && out_ready_i && out_data_o.tx_last,
                     in_ready_o && !out_valid_o, "engine not idle after last byte")

  // A received byte never causes a response byte in the next cycle.
  `MBRTU_ASSERT_NEXT(a_byte_quiet, in_valid_i && in_ready_o && !in_data_i.req_type,
                     !out_valid_o, "response after a data byte")

endmodule

bind modbus_rtu_slave_frame_engine mbrtu_checker u_mbrtu_checker (.*);
`default_nettype wire

// ===== verif/tb_modbus_rtu_slave_frame_engine.sv =====
// Self-checking testbench for the Modbus RTU slave frame engine.
`timescale 1ns / 1ps
`default_nettype none
module tb_modbus_rtu_slave_frame_engine;
  import mbrtu_pkg::*;

  localparam int unsigned FRAME_CAP = FRAME_BYTES_DEF;
  localparam int unsigned REG_CNT   = NUM_REGS_DEF;
  localparam int unsigned COIL_CNT  = NUM_COILS_DEF;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  cfg_valid_i = 1'b0;
  logic  cfg_ready_o;
  logic  [7:0] cfg_data_i = '0;
  logic  in_valid_i = 1'b0;
  logic  in_ready_o;
  req_t  in_data_i = '0;
  logic  out_valid_o;
  logic  out_ready_i = 1'b0;
  resp_t out_data_o;

  modbus_rtu_slave_frame_engine u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the slave state.
  logic [7:0]  shadow_frame [FRAME_CAP];
  int unsigned shadow_len;
  logic [15:0] shadow_crc;
  logic        shadow_open;
  logic [15:0] shadow_regs [REG_CNT];
  logic        shadow_coils [COIL_CNT];
  logic [7:0]  shadow_addr;

  resp_t       pending_bytes [$];
  int unsigned err_count;
  int unsigned frames_sent;
  int unsigned bytes_seen;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          recv_hold;

  function automatic logic [15:0] crc16_byte(logic [15:0] c, logic [7:0] b);
    c = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Append a response, and its CRC low byte first when with_crc is set.
  task automatic queue_reply(input logic [7:0] buf_bytes [$], input bit with_crc);
    logic [15:0] c;
    c = CRC_INIT;
    if (with_crc) begin
      foreach (buf_bytes[i]) c = crc16_byte(c, buf_bytes[i]);
      buf_bytes.push_back(c[7:0]);
      buf_bytes.push_back(c[15:8]);
    end
    foreach (buf_bytes[i]) begin
      pending_bytes.push_back('{tx_byte: buf_bytes[i], tx_last: (i == buf_bytes.size() - 1)});
    end
  endtask

  // Decode a completed frame and predict the answer.
  task automatic predict_frame_end();
    logic [7:0]  r [$];
    logic [7:0]  fn;
    logic [7:0]  acc;
    int unsigned first, arg, nbytes;
    bit          echo;
    echo = 1'b0;
    if (shadow_crc != 16'h0000 || shadow_len < 2) return;
    fn = shadow_frame[1];
    first = {shadow_frame[2], shadow_frame[3]};
    arg = {shadow_frame[4], shadow_frame[5]};
    r.push_back(shadow_frame[0]);
    if (shadow_len == 8 && (fn == FN_WRITE_REG || fn == FN_WRITE_COIL)) begin
      if (fn == FN_WRITE_REG) begin
        if (first < REG_CNT) shadow_regs[first] = arg[15:0];
      end else if (first < COIL_CNT) begin
        if (arg == COIL_ON) shadow_coils[first] = 1'b1;
        else if (arg == COIL_OFF) shadow_coils[first] = 1'b0;
      end
      r.delete();
      for (int i = 0; i < 8; i++) r.push_back(shadow_frame[i]);
      echo = 1'b1;
    end else if (shadow_len == 8 && fn == FN_READ_REGS) begin
      if (arg < 1 || arg > REG_CNT) begin
        r.push_back(fn | EXC_FLAG); r.push_back(EXC_ILL_VALUE);
      end else if (first + arg > REG_CNT) begin
        r.push_back(fn | EXC_FLAG); r.push_back(EXC_ILL_ADDR);
      end else begin
        r.push_back(fn);
        r.push_back(8'(arg * 2));
        for (int i = 0; i < arg; i++) begin
          r.push_back(shadow_regs[first + i][15:8]);
          r.push_back(shadow_regs[first + i][7:0]);
        end
      end
    end else if (shadow_len == 8 && fn == FN_READ_COILS) begin
      if (arg < 1 || arg > COIL_CNT) begin
        r.push_back(fn | EXC_FLAG); r.push_back(EXC_ILL_VALUE);
      end else if (first + arg > COIL_CNT) begin
        r.push_back(fn | EXC_FLAG); r.push_back(EXC_ILL_ADDR);
      end else begin
        nbytes = (arg + 7) / 8;
        r.push_back(fn);
        r.push_back(8'(nbytes));
        for (int j = 0; j < nbytes; j++) begin
          acc = '0;
          for (int i = j * 8; i < arg && i < j * 8 + 8; i++) begin
            acc = {acc[6:0], shadow_coils[first + i]};
          end
          r.push_back(acc);
        end
      end
    end else begin
      r.push_back(fn | EXC_FLAG); r.push_back(EXC_ILL_FUNC);
    end
    if (shadow_frame[0] != BCAST_ADDR) queue_reply(r, !echo);
  endtask

  // Advance the shadow state by one accepted input transaction.
  task automatic predict_item(input req_t it);
    if (!it.req_type) begin
      if (!shadow_open) return;
      shadow_crc = crc16_byte(shadow_crc, it.rx_byte);
      if (shadow_len < FRAME_CAP) begin
        if (shadow_len == 0 && it.rx_byte != BCAST_ADDR && it.rx_byte != shadow_addr) begin
          shadow_open = 1'b0;
          return;
        end
        shadow_frame[shadow_len] = it.rx_byte;
        shadow_len++;
      end
      return;
    end
    if (shadow_open) predict_frame_end();
    shadow_crc = CRC_INIT;
    shadow_len = 0;
    shadow_open = 1'b1;
    frames_sent++;
  endtask

  // Offer one transaction, sometimes after a random gap with valid low; otherwise valid stays up between transactions.
  task automatic send_item(input req_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    predict_item(it);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item('{req_type: 1'b0, rx_byte: b});
  endtask

  task automatic send_end();
    send_item('{req_type: 1'b1, rx_byte: 8'($urandom_range(255))});
  endtask

  // Send a payload, appending a correct CRC when asked.
  task automatic send_frame(input logic [7:0] body [$], input bit good_crc);
    logic [15:0] c;
    c = CRC_INIT;
    foreach (body[i]) begin
      c = crc16_byte(c, body[i]);
      send_byte(body[i]);
    end
    if (good_crc) begin
      send_byte(c[7:0]);
      send_byte(c[15:8]);
    end
    send_end();
  endtask

  task automatic send_request(input logic [7:0] a, input logic [7:0] fn,
                              input logic [15:0] p1, input logic [15:0] p2);
    logic [7:0] body [$];
    body = '{a, fn, p1[15:8], p1[7:0], p2[15:8], p2[7:0]};
    send_frame(body, 1'b1);
  endtask

  task automatic drain();
    int unsigned guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (pending_bytes.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_address(input logic [7:0] a);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= a;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    shadow_addr = a;
  endtask

  // Receiver: random stalls, and one long hold-off on request.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_ready_i <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each response transaction with the oldest prediction.
  always @(posedge clk_i) begin
    resp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      bytes_seen++;
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected response byte %h last %b", $time,
                 out_data_o.tx_byte, out_data_o.tx_last);
        err_count++;
      end else begin
        want = pending_bytes.pop_front();
        if (want.tx_byte !== out_data_o.tx_byte) begin
          $display("%0t: tx_byte expected %h actual %h", $time, want.tx_byte,
                   out_data_o.tx_byte);
          err_count++;
        end
        if (want.tx_last !== out_data_o.tx_last) begin
          $display("%0t: tx_last expected %b actual %b", $time, want.tx_last,
                   out_data_o.tx_last);
          err_count++;
        end
      end
    end
  end

  // Directed rows: address, function, two words, and whether the CRC is good.
  typedef struct {
    logic [7:0]  addr;
    logic [7:0]  fn;
    logic [15:0] p1;
    logic [15:0] p2;
    bit          good;
    int          exc;
  } row_t;

  row_t rows [$];

  task automatic random_frame();
    logic [7:0] body [$];
    logic [7:0] fn;
    logic [7:0] a;
    int unsigned pick;
    pick = $urandom_range(99);
    a = ($urandom_range(9) == 0) ? BCAST_ADDR : shadow_addr;
    if ($urandom_range(19) == 0) a = 8'($urandom_range(255));
    case ($urandom_range(3))
      0: fn = FN_READ_REGS;
      1: fn = FN_READ_COILS;
      2: fn = FN_WRITE_REG;
      default: fn = FN_WRITE_COIL;
    endcase
    if (pick < 75) begin
      if (fn == FN_READ_REGS)
        send_request(a, fn, 16'($urandom_range(17)), 16'($urandom_range(17)));
      else if (fn == FN_READ_COILS)
        send_request(a, fn, 16'($urandom_range(66)), 16'($urandom_range(66)));
      else if (fn == FN_WRITE_COIL)
        send_request(a, fn, 16'($urandom_range(66)),
                     ($urandom_range(3) == 0) ? 16'($urandom) :
                     ($urandom_range(1) ? COIL_ON : COIL_OFF));
      else
        send_request(a, fn, ($urandom_range(9) == 0) ? 16'($urandom) :
                     16'($urandom_range(17)), 16'($urandom));
    end else if (pick < 85) begin
      send_request(a, 8'($urandom), 16'($urandom), 16'($urandom));
    end else begin
      // Odd lengths, broken CRCs, and bare noise.
      body.push_back(a);
      repeat ($urandom_range(12)) body.push_back(8'($urandom));
      send_frame(body, $urandom_range(1));
    end
  endtask

  initial begin
    err_count = 0; frames_sent = 0; bytes_seen = 0;
    send_idle_pct = 0; recv_idle_pct = 0; recv_hold = 1'b0;
    shadow_len = 0; shadow_crc = CRC_INIT; shadow_open = 1'b1; shadow_addr = '0;
    foreach (shadow_frame[i]) shadow_frame[i] = '0;
    foreach (shadow_regs[i]) shadow_regs[i] = '0;
    foreach (shadow_coils[i]) shadow_coils[i] = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset address, then at the top address.
    rows = '{
      '{8'h00, FN_READ_REGS,  16'd0,  16'd16,   1'b1, -1},
      '{8'h00, FN_WRITE_REG,  16'd15, 16'hFFFF, 1'b1, -1},
      '{8'h00, FN_WRITE_COIL, 16'd63, COIL_ON,  1'b1, -1}
    };
    foreach (rows[i]) send_request(rows[i].addr, rows[i].fn, rows[i].p1, rows[i].p2);
    drain();
    write_address(8'd247);
    rows = '{
      '{8'd247, FN_READ_REGS,  16'd0,  16'd16,   1'b1, -1},
      '{8'd247, FN_READ_REGS,  16'd0,  16'd0,    1'b1, EXC_ILL_VALUE},
      '{8'd247, FN_READ_REGS,  16'd15, 16'd2,    1'b1, EXC_ILL_ADDR},
      '{8'd247, FN_READ_REGS,  16'd0,  16'd17,   1'b1, EXC_ILL_VALUE},
      '{8'd247, FN_READ_COILS, 16'd0,  16'd64,   1'b1, -1},
      '{8'd247, FN_READ_COILS, 16'd60, 16'd5,    1'b1, EXC_ILL_ADDR},
      '{8'd247, FN_READ_COILS, 16'd0,  16'd65,   1'b1, EXC_ILL_VALUE},
      '{8'd247, FN_WRITE_COIL, 16'd0,  COIL_ON,  1'b1, -1},
      '{8'd247, FN_WRITE_COIL, 16'd1,  16'h1234, 1'b1, -1},
      '{8'd247, FN_WRITE_COIL, 16'd99, COIL_ON,  1'b1, -1},
      '{8'd247, FN_WRITE_REG,  16'd0,  16'hA5C3, 1'b1, -1},
      '{8'd247, FN_WRITE_REG,  16'hFFFF, 16'h1, 1'b1, -1},
      '{8'd247, FN_READ_COILS, 16'd58, 16'd6,    1'b1, -1},
      '{8'd247, 8'h10,         16'd0,  16'd1,    1'b1, EXC_ILL_FUNC},
      '{8'd247, 8'hFF,         16'hFFFF, 16'hFFFF, 1'b1, EXC_ILL_FUNC},
      '{8'd5,   FN_READ_REGS,  16'd0,  16'd1,    1'b1, -1}
    };
    foreach (rows[i]) begin
      if (rows[i].exc >= 0) begin
        // Exception replies are easy to spell out by hand; check the predictor too.
        send_request(rows[i].addr, rows[i].fn, rows[i].p1, rows[i].p2);
        if (pending_bytes.size() < 5 || pending_bytes[pending_bytes.size() - 3].tx_byte
            !== 8'(rows[i].exc)) begin
          $display("%0t: exception code expected %h actual prediction differs", $time,
                   8'(rows[i].exc));
          err_count++;
        end
      end else begin
        send_request(rows[i].addr, rows[i].fn, rows[i].p1, rows[i].p2);
      end
    end
    // Overflow frame and a frame with a broken CRC.
    begin
      logic [7:0] body [$];
      body.push_back(8'd247);
      repeat (70) body.push_back(8'($urandom));
      send_frame(body, 1'b1);
      body = '{8'd247, FN_READ_REGS, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00};
      send_frame(body, 1'b0);
    end
    drain();

    // Pressure: the receiver holds off while reads keep coming.
    recv_hold = 1'b1;
    fork
      begin
        repeat (3000) @(posedge clk_i);
        recv_hold = 1'b0;
      end
      repeat (6) send_request(8'd247, FN_READ_REGS, 16'd0, 16'd16);
    join
    drain();

    // Random part in three idling phases, each with its own address.
    for (int ph = 0; ph < 3; ph++) begin
      drain();
      send_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 81 : 0;
      recv_idle_pct = (ph == 0) ? 81 : (ph == 1) ? 15 : 0;
      write_address((ph == 0) ? 8'd1 : (ph == 1) ? 8'($urandom_range(2, 246)) : 8'd0);
      repeat (6) random_frame();
    end
    drain();
    write_address(8'd247);
    recv_idle_pct = 0;
    send_idle_pct = 0;
    repeat (6) random_frame();
    drain();

    $display("Covered %0d frames and %0d response bytes over address, read, write,",
             frames_sent, bytes_seen);
    $display("exception, overflow, bad-CRC and backpressure cases.");
    if (err_count == 0 && pending_bytes.size() == 0) begin
      $display("tb_modbus_rtu_slave_frame_engine: done, clean");
    end else begin
      $display("tb_modbus_rtu_slave_frame_engine: done, errors");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #50ms;
    $display("tb_modbus_rtu_slave_frame_engine: done, errors");
    $finish;
  end

endmodule
`default_nettype wire
